/* design/xsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr_pkg
// Shared types and constants for the xoshiro256** generator with SplitMix64
// seeding: mixing constants, input kind codes, the controller state encoding
// and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package xsr_pkg;

    // SplitMix64 constants.
    localparam logic [63:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] SM_MUL2  = 64'h94d0_49bb_1331_11eb;

    // Kind carried in tuser.
    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_NEXT = 1'b1;

    // Which 32x32 partial product the shared multiplier forms.
    localparam logic [1:0] MUL_LL = 2'd0;  // low  x low
    localparam logic [1:0] MUL_LH = 2'd1;  // low  x high
    localparam logic [1:0] MUL_HL = 2'd2;  // high x low

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ADD    = 7'b0000010,
        S_MUL_LL = 7'b0000100,
        S_MUL_LH = 7'b0001000,
        S_MUL_HL = 7'b0010000,
        S_XS     = 7'b0100000,
        S_STORE  = 7'b1000000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_seed;  // capture seed into the SplitMix counter
        logic       next_word;  // produce an output word and advance state
        logic       mix_add;    // counter += gamma, first xor-shift by 30
        logic       mul_en;     // accumulate one partial product
        logic [1:0] mul_part;   // which partial product
        logic       mul_const;  // 0: first mixing constant, 1: second
        logic       mix_xs;     // xor-shift by 27 between the multiplies
        logic       store;      // final xor-shift by 31 into a state word
        logic [1:0] word_idx;   // state word being seeded
    } t_dp_cmd;

endpackage

/* design/xoshiro256_prng_with_splitmix_seed.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoshiro256_prng_with_splitmix_seed
// xoshiro256** 64-bit pseudo-random generator seeded through SplitMix64.
// ----------------------------------------------------------------------------
// A transaction with tuser = 0 seeds the generator from tdata and gives no
// output; one with tuser = 1 returns the next scrambled 64-bit word. Next-word
// requests are taken one per cycle, as long as the output side keeps up; a
// new request is taken in the same cycle that the previous word leaves the
// output register, and input stalls while a word waits there. A
// seed, once taken, holds off further transactions while four SplitMix64
// rounds run, each an add, two multiplies and a store, on the single 32x32
// multiplier that forms each 64-bit product in three partial products.
// After reset the state is all zero and every word is zero until seeded.
module xoshiro256_prng_with_splitmix_seed (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] seed_value
    input  logic [0:0]  i_s_axis_tuser,   // [0] kind (0 seed, 1 next)
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [63:0] random_word
);
    import xsr_pkg::*;

    t_dp_cmd cmd;

    // Sequencer and handshakes.
    xsr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tuser  (i_s_axis_tuser[0]),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_cmd           (cmd)
    );

    // State and arithmetic.
    xsr_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_seed  (i_s_axis_tdata),
        .o_word  (o_m_axis_tdata)
    );

endmodule

/* design/xsr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr_ctrl
// Controller: input and output handshakes, and the sequencer that walks
// the datapath through four SplitMix64 rounds when a seed is taken.
// ----------------------------------------------------------------------------
module xsr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic            i_s_axis_tuser,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output xsr_pkg::t_dp_cmd o_cmd
);
    import xsr_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_word, n_word;
    logic       r_pass, n_pass;
    logic       r_out_valid, n_out_valid;
    logic       in_acc;

    // Input is taken only in idle and when the output register can move.
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;

    // Next-state logic and datapath commands.
    always_comb begin
        n_state        = r_state;
        n_word         = r_word;
        n_pass         = r_pass;
        o_cmd          = '0;
        o_cmd.word_idx = r_word;
        o_cmd.mul_const = r_pass;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_s_axis_tuser == KIND_SEED) begin
                        o_cmd.load_seed = 1'b1;
                        n_state         = S_ADD;
                        n_word          = 2'd0;
                    end else begin
                        o_cmd.next_word = 1'b1;
                    end
                end
            end
            S_ADD: begin
                o_cmd.mix_add = 1'b1;
                n_pass        = 1'b0;
                n_state       = S_MUL_LL;
            end
            S_MUL_LL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_part = MUL_LL;
                n_state        = S_MUL_LH;
            end
            S_MUL_LH: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_part = MUL_LH;
                n_state        = S_MUL_HL;
            end
            S_MUL_HL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_part = MUL_HL;
                n_state        = r_pass ? S_STORE : S_XS;
            end
            S_XS: begin
                o_cmd.mix_xs = 1'b1;
                n_pass       = 1'b1;
                n_state      = S_MUL_LL;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_word      = r_word + 2'd1;
                n_state     = (r_word == 2'd3) ? S_IDLE : S_ADD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set by a next-word transaction, cleared when taken.
    always_comb begin
        if (in_acc && (i_s_axis_tuser == KIND_NEXT)) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_word      <= 2'd0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* design/xsr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr_dp
// Datapath: the four state words, the xoshiro256** output scrambler and
// update, and the SplitMix64 mixer built on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module xsr_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  xsr_pkg::t_dp_cmd i_cmd,
    input  logic [63:0]      i_seed,
    output logic [63:0]      o_word
);
    import xsr_pkg::*;

    logic [63:0] r_s [4];
    logic [63:0] r_acc;
    logic [63:0] r_z;
    logic [63:0] r_prod;
    logic [63:0] r_out;

    logic [63:0] n_acc;
    logic [63:0] m_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] n_prod;
    logic [63:0] s1x5;
    logic [63:0] s1rot;
    logic [63:0] out_word;
    logic [63:0] t2;
    logic [63:0] t3;

    assign o_word = r_out;

    // SplitMix64 counter step.
    assign n_acc   = r_acc + SM_GAMMA;
    assign m_const = i_cmd.mul_const ? SM_MUL2 : SM_MUL1;

    // Shared multiplier: the low 64 bits of a 64x64 product in three parts.
    always_comb begin
        case (i_cmd.mul_part)
            MUL_LL: begin
                mul_a = r_z[31:0];
                mul_b = m_const[31:0];
            end
            MUL_LH: begin
                mul_a = r_z[31:0];
                mul_b = m_const[63:32];
            end
            MUL_HL: begin
                mul_a = r_z[63:32];
                mul_b = m_const[31:0];
            end
            default: begin
                mul_a = r_z[31:0];
                mul_b = m_const[31:0];
            end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
        if (i_cmd.mul_part == MUL_LL) begin
            n_prod = mul_p;
        end else begin
            n_prod = {r_prod[63:32] + mul_p[31:0], r_prod[31:0]};
        end
    end

    // Output scrambler: rotl(s1 * 5, 7) * 9 with shift-adds.
    assign s1x5     = r_s[1] + (r_s[1] << 2);
    assign s1rot    = {s1x5[56:0], s1x5[63:57]};
    assign out_word = s1rot + (s1rot << 3);

    // Intermediate terms of the state update.
    assign t2 = r_s[2] ^ r_s[0];
    assign t3 = r_s[3] ^ r_s[1];

    // State words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s[0] <= '0;
            r_s[1] <= '0;
            r_s[2] <= '0;
            r_s[3] <= '0;
        end else if (i_cmd.next_word) begin
            r_s[0] <= r_s[0] ^ t3;
            r_s[1] <= r_s[1] ^ t2;
            r_s[2] <= t2 ^ (r_s[1] << 17);
            r_s[3] <= {t3[18:0], t3[63:19]};
        end else if (i_cmd.store) begin
            r_s[i_cmd.word_idx] <= r_prod ^ (r_prod >> 31);
        end
    end

    // Seeding registers and the output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_acc <= i_seed;
        end else if (i_cmd.mix_add) begin
            r_acc <= n_acc;
        end
        if (i_cmd.mix_add) begin
            r_z <= n_acc ^ (n_acc >> 30);
        end else if (i_cmd.mix_xs) begin
            r_z <= r_prod ^ (r_prod >> 27);
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.next_word) begin
            r_out <= out_word;
        end
    end

endmodule

/* design/xsr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr_checker
// Port-level checks for the generator, bound to the top level.
// ----------------------------------------------------------------------------
module xsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [0:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata
);
    import xsr_pkg::*;

    logic in_acc;
    logic out_free;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !o_m_axis_tvalid || i_m_axis_tready;

    // No word is pending after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output word changed");

    // A next-word transaction yields a word in the following cycle.
    a_next_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_s_axis_tuser[0] == KIND_NEXT) |=> o_m_axis_tvalid)
        else $error("next-word transaction gave no output");

    // A seed transaction gives no word and holds off input as mixing begins.
    a_seed_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_s_axis_tuser[0] == KIND_SEED) && out_free
        |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("seed transaction produced output or did not stall input");

endmodule

bind xoshiro256_prng_with_splitmix_seed xsr_checker u_xsr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
